/* design/q2e_pkg.sv */
// Shared constants, types and helpers for the quaternion to Euler angle core.
package q2e_pkg;

  localparam int QW                = 16;  // input component width, Q2.14
  localparam int PW                = 32;  // 16x16 product width
  localparam int TW                = 34;  // matrix term width, Q28
  localparam int NW                = 58;  // square root working width
  localparam int CW                = 44;  // CORDIC x/y width
  localparam int AW                = 34;  // CORDIC angle width, pi = 2^31
  localparam int BW                = AW - 16;  // angle after rounding to 16 fraction bits
  localparam int AngW              = 16;  // output angle width
  localparam int SQ_STEPS          = 29;  // root bits for an argument up to 2^56
  localparam int NORM_STEPS        = 6;   // shifts 32,16,8,4,2,1
  localparam int NORM_TOP          = 41;  // normalized magnitude sits in [2^40, 2^41)
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TAB_DEPTH         = 24;

  localparam logic signed [TW-1:0] ONE_Q28   = TW'(64'sd268435456);
  localparam logic signed [TW-1:0] M_ONE_Q28 = -ONE_Q28;
  localparam logic [NW-1:0]        SQ_ONE    = NW'(1) << 56;
  localparam logic signed [AW-1:0] ACC_PI    = AW'(1) << 31;
  localparam logic signed [BW-1:0] PITCH_MAX = BW'(16384);
  localparam logic signed [BW-1:0] PITCH_MIN = -PITCH_MAX;
  localparam logic [15:0]          THR_RESET = 16'd1;

  // atan(2^-i) with pi = 2^31
  localparam logic [31:0] ATAN_TAB [TAB_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [AngW-1:0] roll_angle;
    logic signed [AngW-1:0] pitch_angle;
    logic signed [AngW-1:0] yaw_angle;
    logic                   gimbal_locked;
  } euler_t;

  // root iteration state
  typedef struct packed {
    logic [NW-1:0] n;
    logic [NW-1:0] res;
  } sq_t;

  // terms riding along with the root iterations
  typedef struct packed {
    logic signed [TW-1:0] roll_y;
    logic signed [TW-1:0] roll_x;
    logic signed [TW-1:0] yaw_y;
    logic signed [TW-1:0] yaw_x;
    logic signed [TW-1:0] s;
    logic                 normal;
  } sq_side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
  } cordic_t;

  // round to nearest, half up, keeping 16 fraction bits fewer
  function automatic logic signed [BW-1:0] to_bangle(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] t;
    t = acc + AW'(32768);
    return t[AW-1:16];
  endfunction

endpackage

/* design/q2e_if.sv */
// Channel interfaces: quaternion words in, Euler words out, threshold writes.
interface q2e_quat_if;
  import q2e_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
  import q2e_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [AngW-1:0] roll_angle;
  logic signed [AngW-1:0] pitch_angle;
  logic signed [AngW-1:0] yaw_angle;
  logic                   gimbal_locked;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, gimbal_locked,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, gimbal_locked,
                  output ready);
endinterface

interface q2e_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] gimbal_threshold;
  modport source (output valid, gimbal_threshold, input ready);
  modport sink   (input valid, gimbal_threshold, output ready);
endinterface

/* design/q2e_front.sv */
// Front pipeline: matrix terms, gimbal test and root argument, five stages.
module q2e_front (
  input  logic              clk,
  input  logic              en,
  input  q2e_pkg::quat_t    q_i,
  input  logic [15:0]       thr_i,
  output logic [q2e_pkg::NW-1:0] n_o,
  output q2e_pkg::sq_side_t side_o
);
  import q2e_pkg::*;

  typedef struct packed {
    logic signed [TW-1:0] r00;
    logic signed [TW-1:0] r10;
    logic signed [TW-1:0] r11;
    logic signed [TW-1:0] r12;
    logic signed [TW-1:0] r21;
    logic signed [TW-1:0] r22;
  } terms_t;

  // stage 1: products
  logic signed [PW-1:0] p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_wz_r;
  logic signed [PW-1:0] p_yz_r, p_wx_r, p_wy_r, p_xz_r;
  // stage 2: terms
  terms_t               t2_r;
  logic signed [TW-1:0] s2_r;
  // stage 3: magnitudes, saturated sine
  terms_t               t3_r;
  logic                 big3_r;
  logic [30:0]          u0_r, u1_r;
  logic signed [TW-1:0] s3_r;
  logic [28:0]          smag_r;
  // stage 4: squares
  terms_t               t4_r;
  logic                 big4_r;
  logic [61:0]          u0sq_r, u1sq_r;
  logic [57:0]          ssq_r;
  logic signed [TW-1:0] s4_r;

  logic signed [TW-1:0] a0, a1, s_sat;
  logic [62:0]          sqsum;
  logic                 normal;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx_r <= q_i.quat_x * q_i.quat_x;
      p_yy_r <= q_i.quat_y * q_i.quat_y;
      p_zz_r <= q_i.quat_z * q_i.quat_z;
      p_xy_r <= q_i.quat_x * q_i.quat_y;
      p_wz_r <= q_i.quat_w * q_i.quat_z;
      p_yz_r <= q_i.quat_y * q_i.quat_z;
      p_wx_r <= q_i.quat_w * q_i.quat_x;
      p_wy_r <= q_i.quat_w * q_i.quat_y;
      p_xz_r <= q_i.quat_x * q_i.quat_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r.r00 <= ONE_Q28 - ((TW'(p_yy_r) + TW'(p_zz_r)) <<< 1);
      t2_r.r10 <= (TW'(p_xy_r) + TW'(p_wz_r)) <<< 1;
      t2_r.r11 <= ONE_Q28 - ((TW'(p_xx_r) + TW'(p_zz_r)) <<< 1);
      t2_r.r12 <= (TW'(p_yz_r) - TW'(p_wx_r)) <<< 1;
      t2_r.r21 <= (TW'(p_yz_r) + TW'(p_wx_r)) <<< 1;
      t2_r.r22 <= ONE_Q28 - ((TW'(p_xx_r) + TW'(p_yy_r)) <<< 1);
      s2_r     <= (TW'(p_wy_r) - TW'(p_xz_r)) <<< 1;
    end
  end

  always_comb begin
    a0 = (t2_r.r00 < 0) ? -t2_r.r00 : t2_r.r00;
    a1 = (t2_r.r10 < 0) ? -t2_r.r10 : t2_r.r10;
    if (s2_r > ONE_Q28) begin
      s_sat = ONE_Q28;
    end else if (s2_r < M_ONE_Q28) begin
      s_sat = M_ONE_Q28;
    end else begin
      s_sat = s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r   <= t2_r;
      big3_r <= (a0[TW-1:31] != '0) || (a1[TW-1:31] != '0);
      u0_r   <= a0[30:0];
      u1_r   <= a1[30:0];
      s3_r   <= s_sat;
      smag_r <= (s_sat < 0) ? 29'(-s_sat) : 29'(s_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_r   <= t3_r;
      big4_r <= big3_r;
      u0sq_r <= u0_r * u0_r;
      u1sq_r <= u1_r * u1_r;
      ssq_r  <= smag_r * smag_r;
      s4_r   <= s3_r;
    end
  end

  always_comb begin
    sqsum  = {1'b0, u0sq_r} + {1'b0, u1sq_r};
    normal = big4_r || (sqsum[62:28] >= 35'(thr_i));
  end

  // singular branch: roll from atan2(-R12, R11), yaw arguments zeroed so yaw reads 0
  always_ff @(posedge clk) begin
    if (en) begin
      n_o           <= SQ_ONE - NW'(ssq_r);
      side_o.roll_y <= normal ? t4_r.r21 : -t4_r.r12;
      side_o.roll_x <= normal ? t4_r.r22 : t4_r.r11;
      side_o.yaw_y  <= normal ? t4_r.r10 : '0;
      side_o.yaw_x  <= normal ? t4_r.r00 : '0;
      side_o.s      <= s4_r;
      side_o.normal <= normal;
    end
  end

endmodule

/* design/q2e_sqrt_cell.sv */
// One restoring square root step, one result bit, with side terms in tow.
module q2e_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  q2e_pkg::sq_t      d_i,
  input  q2e_pkg::sq_side_t side_i,
  output q2e_pkg::sq_t      d_o,
  output q2e_pkg::sq_side_t side_o
);
  import q2e_pkg::*;

  localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQ_STEPS - 1 - STEP));

  logic [NW-1:0] trial;

  assign trial = d_i.res + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      if (d_i.n >= trial) begin
        d_o.n   <= d_i.n - trial;
        d_o.res <= (d_i.res >> 1) + BIT;
      end else begin
        d_o.n   <= d_i.n;
        d_o.res <= d_i.res >> 1;
      end
    end
  end

endmodule

/* design/q2e_cordic_cell.sv */
// One vectoring CORDIC rotation.
module q2e_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  q2e_pkg::cordic_t c_i,
  output q2e_pkg::cordic_t c_o
);
  import q2e_pkg::*;

  localparam logic signed [AW-1:0] ANG = AW'(ATAN_TAB[STEP]);

  logic signed [CW-1:0] dx, dy;

  assign dx = c_i.y >>> STEP;
  assign dy = c_i.x >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      c_o.zero <= c_i.zero;
      if (c_i.y >= 0) begin
        c_o.x   <= c_i.x + dx;
        c_o.y   <= c_i.y - dy;
        c_o.acc <= c_i.acc + ANG;
      end else begin
        c_o.x   <= c_i.x - dx;
        c_o.y   <= c_i.y + dy;
        c_o.acc <= c_i.acc - ANG;
      end
    end
  end

endmodule

/* design/q2e_atan_lane.sv */
// atan2 lane: half-plane fold, normalizing shifts, then the CORDIC cells.
module q2e_atan_lane #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [q2e_pkg::TW-1:0] y_i,
  input  logic signed [q2e_pkg::TW-1:0] x_i,
  output logic signed [q2e_pkg::AW-1:0] acc_o,
  output logic                          zero_o
);
  import q2e_pkg::*;

  cordic_t       st_r [NORM_STEPS+1];
  logic [CW-1:0] m_r  [NORM_STEPS];
  cordic_t       cs   [STAGES+1];

  logic signed [CW-1:0] xe, ye, xf, yf, ya;
  logic                 neg;

  always_comb begin
    xe  = CW'(x_i);
    ye  = CW'(y_i);
    neg = x_i < 0;
    xf  = neg ? -xe : xe;
    yf  = neg ? -ye : ye;
    ya  = (yf < 0) ? -yf : yf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].x    <= xf;
      st_r[0].y    <= yf;
      st_r[0].acc  <= neg ? ACC_PI : '0;
      st_r[0].zero <= (x_i == '0) && (y_i == '0);
      m_r[0]       <= (xf > ya) ? xf : ya;
    end
  end

  // binary shift search: take each shift while the larger magnitude stays below 2^41
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int S = 1 << (NORM_STEPS - 1 - j);
    logic take;
    assign take = (m_r[j] >> (NORM_TOP - S)) == '0;
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j+1].acc  <= st_r[j].acc;
        st_r[j+1].zero <= st_r[j].zero;
        st_r[j+1].x    <= take ? (st_r[j].x <<< S) : st_r[j].x;
        st_r[j+1].y    <= take ? (st_r[j].y <<< S) : st_r[j].y;
      end
    end
    if (j + 1 < NORM_STEPS) begin : g_m
      always_ff @(posedge clk) begin
        if (en) begin
          m_r[j+1] <= take ? (m_r[j] << S) : m_r[j];
        end
      end
    end
  end

  assign cs[0] = st_r[NORM_STEPS];

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    q2e_cordic_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .en  (en),
      .c_i (cs[i]),
      .c_o (cs[i+1])
    );
  end

  assign acc_o  = cs[STAGES].acc;
  assign zero_o = cs[STAGES].zero;

endmodule

/* design/quaternion_to_euler_angles_core.sv */
// Top level: quaternion in, ZYX roll/pitch/yaw binary angles out.
//
// One quaternion word is accepted every clock cycle while the skid entry is
// empty, and one Euler word comes out per input, in order. From accept to
// out_chan.valid a word passes 5 front stages (products, matrix terms,
// magnitudes, squares, gimbal test), 29 square root cells, the half-plane
// fold and normalizing shifts, CORDIC_STAGES rotation cells, and
// the output register. Three atan2 lanes run side by side on the same clock.
// A two-entry output stage (output register plus skid) keeps in_chan.ready
// high when the consumer first stalls; ready drops only once the skid
// entry is full, and ready never depends on out_chan.ready in the same cycle.
// gimbal_threshold is taken in the fifth front stage; write it only while no
// words are in flight. cfg_chan.ready is always high.
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  q2e_quat_if.sink     in_chan,
  q2e_euler_if.source  out_chan,
  q2e_cfg_if.sink      cfg_chan
);
  import q2e_pkg::*;

  localparam int LANE_LAT = 1 + NORM_STEPS + CORDIC_STAGES;
  localparam int LAT      = 5 + SQ_STEPS + LANE_LAT;

  logic [15:0]     thr_r;
  logic [LAT-1:0]  vld_r;
  logic [LANE_LAT-1:0] nd_r;   // normal-branch flag alongside the lanes
  logic            en, in_fire, fin_v;
  quat_t           q_in;
  euler_t          fin, out_r, skid_r;
  logic            out_v_r, skid_v_r;

  sq_t             sq_s   [SQ_STEPS+1];
  sq_side_t        side_s [SQ_STEPS+1];

  logic signed [AW-1:0] roll_acc, pitch_acc, yaw_acc;
  logic                 roll_zero, pitch_zero, yaw_zero;
  logic signed [BW-1:0] roll_b, pitch_b, yaw_b;

  // whole pipeline moves unless the skid word is occupied
  assign en       = !skid_v_r;
  assign in_fire  = in_chan.valid && en;
  assign in_chan.ready  = en;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_chan.valid) begin
      thr_r <= cfg_chan.gimbal_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_fire};
    end
  end

  assign q_in.quat_w = in_chan.quat_w;
  assign q_in.quat_x = in_chan.quat_x;
  assign q_in.quat_y = in_chan.quat_y;
  assign q_in.quat_z = in_chan.quat_z;

  q2e_front u_front (
    .clk    (clk),
    .en     (en),
    .q_i    (q_in),
    .thr_i  (thr_r),
    .n_o    (sq_s[0].n),
    .side_o (side_s[0])
  );
  assign sq_s[0].res = '0;

  // cos(pitch) = sqrt(1 - s^2), one result bit per cell
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    q2e_sqrt_cell #(.STEP(k)) u_sq (
      .clk    (clk),
      .en     (en),
      .d_i    (sq_s[k]),
      .side_i (side_s[k]),
      .d_o    (sq_s[k+1]),
      .side_o (side_s[k+1])
    );
  end

  q2e_atan_lane #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .en (en),
    .y_i (side_s[SQ_STEPS].roll_y), .x_i (side_s[SQ_STEPS].roll_x),
    .acc_o (roll_acc), .zero_o (roll_zero)
  );

  q2e_atan_lane #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .en (en),
    .y_i (side_s[SQ_STEPS].s), .x_i (TW'(sq_s[SQ_STEPS].res)),
    .acc_o (pitch_acc), .zero_o (pitch_zero)
  );

  q2e_atan_lane #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .en (en),
    .y_i (side_s[SQ_STEPS].yaw_y), .x_i (side_s[SQ_STEPS].yaw_x),
    .acc_o (yaw_acc), .zero_o (yaw_zero)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nd_r <= {nd_r[LANE_LAT-2:0], side_s[SQ_STEPS].normal};
    end
  end

  // atan2(0,0) reads as zero; yaw lane sees (0,0) in the singular branch
  always_comb begin
    roll_b  = to_bangle(roll_zero  ? '0 : roll_acc);
    pitch_b = to_bangle(pitch_zero ? '0 : pitch_acc);
    yaw_b   = to_bangle(yaw_zero   ? '0 : yaw_acc);
    if (pitch_b > PITCH_MAX) begin
      pitch_b = PITCH_MAX;
    end else if (pitch_b < PITCH_MIN) begin
      pitch_b = PITCH_MIN;
    end
    fin.roll_angle    = roll_b[AngW-1:0];
    fin.pitch_angle   = pitch_b[AngW-1:0];
    fin.yaw_angle     = yaw_b[AngW-1:0];
    fin.gimbal_locked = !nd_r[LANE_LAT-1];
  end

  assign fin_v = vld_r[LAT-1] && en;

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_chan.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= fin_v;
      end else begin
        out_v_r <= fin_v;
      end
    end else if (fin_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_chan.ready) begin
      if (skid_v_r) begin
        out_r  <= skid_r;
        skid_r <= fin;
      end else begin
        out_r <= fin;
      end
    end else if (fin_v) begin
      skid_r <= fin;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.roll_angle    = out_r.roll_angle;
  assign out_chan.pitch_angle   = out_r.pitch_angle;
  assign out_chan.yaw_angle     = out_r.yaw_angle;
  assign out_chan.gimbal_locked = out_r.gimbal_locked;

endmodule

/* design/q2e_checker.sv */
// Port-level checks for the quaternion to Euler core, bound to the top level.
module q2e_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] roll_angle,
  input logic signed [15:0] pitch_angle,
  input logic signed [15:0] yaw_angle,
  input logic               gimbal_locked
);

  logic stall;
  assign stall = out_valid && !out_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> out_valid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(roll_angle) && $stable(pitch_angle) && $stable(yaw_angle)
              && $stable(gimbal_locked))
    else $error("out word changed while stalled");

  a_lock_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && gimbal_locked |-> yaw_angle == 16'sd0)
    else $error("yaw not zero in gimbal lock");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pitch_angle <= 16'sd16384) && (pitch_angle >= -16'sd16384))
    else $error("pitch outside +-pi/2");

  // skid word is free on the first stalled cycle, so input keeps flowing
  a_skid_ready: assert property (@(posedge clk) disable iff (!rst_n)
    stall && !$past(stall) |-> in_ready)
    else $error("input stalled on first output stall cycle");

endmodule

bind quaternion_to_euler_angles_core q2e_checker u_q2e_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .roll_angle    (out_chan.roll_angle),
  .pitch_angle   (out_chan.pitch_angle),
  .yaw_angle     (out_chan.yaw_angle),
  .gimbal_locked (out_chan.gimbal_locked)
);
